@@ rtl/core/clc_pkg.sv @@
// Shared types and constants for the line comment locator.
// No dependencies; imported by every module of the block.
package clc_pkg;

  localparam int MAX_DELIM = 16;
  localparam int WIN_SIZE  = MAX_DELIM + 2;
  localparam int DLEN_W    = $clog2(MAX_DELIM + 1);
  localparam int DIDX_W    = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam int WIDX_W    = $clog2(WIN_SIZE);
  localparam int WFILL_W   = $clog2(WIN_SIZE + 1);
  localparam int COL_W     = 16;
  localparam int OUT_DW    = 24;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_BLOCK  = 3'd1;
  localparam logic [2:0] MODE_STRING = 3'd2;
  localparam logic [2:0] MODE_DELIM  = 3'd3;
  localparam logic [2:0] MODE_RAW    = 3'd4;
  localparam logic [2:0] MODE_DEAD   = 3'd5;
  localparam logic [2:0] MODE_FOUND  = 3'd6;

  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_L      = 8'h4c;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_USCORE = 8'h5f;

  typedef struct packed {
    logic             found;
    logic [COL_W-1:0] column;
    logic             in_block;
    logic             in_raw;
  } result_t;

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_USCORE);
  endfunction

endpackage

@@ rtl/core/clc_scan.sv @@
// Lexer state and per-character next-state logic; emits one result per line end.
// Depends on clc_pkg.
module clc_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  logic             line_end,
  input  logic [7:0]       ch,
  output logic             res_valid,
  output clc_pkg::result_t res
);
  import clc_pkg::*;

  logic [2:0]         mode_r, mode_nxt;
  logic               pslash_r, pslash_nxt;
  logic               star_r, star_nxt;
  logic               esc_r, esc_nxt;
  logic               qkind_r, qkind_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [COL_W-1:0]   fcol_r, fcol_nxt;
  logic [DLEN_W-1:0]  dlen_r, dlen_nxt;
  logic [WFILL_W-1:0] fill_r, fill_nxt;
  logic               pure_r, pure_nxt;
  logic               rready_r, rready_nxt;
  logic [7:0]         delim_r [MAX_DELIM];
  logic [7:0]         win_r [WIN_SIZE];
  logic [7:0]         win_nxt [WIN_SIZE];
  logic               dwr;
  logic               win_upd;
  logic [WFILL_W-1:0] need;
  logic [WFILL_W-1:0] wfill_push;
  logic               win_hit;
  logic               is_pfx;

  // terminator window after pushing ch
  always_comb begin
    need = WFILL_W'(dlen_r) + WFILL_W'(2);
    for (int i = 0; i < WIN_SIZE; i++) begin
      if (fill_r < need) begin
        win_nxt[i] = (WFILL_W'(i) == fill_r) ? ch : win_r[i];
      end else if (WFILL_W'(i) < need - WFILL_W'(1)) begin
        win_nxt[i] = (i < WIN_SIZE - 1) ? win_r[(i + 1) % WIN_SIZE] : win_r[i];
      end else if (WFILL_W'(i) == need - WFILL_W'(1)) begin
        win_nxt[i] = ch;
      end else begin
        win_nxt[i] = win_r[i];
      end
    end
    wfill_push = (fill_r < need) ? fill_r + WFILL_W'(1) : fill_r;
    // last slot always holds ch once the window is full
    win_hit = (wfill_push == need) && (ch == CH_DQUOTE) && (win_nxt[0] == CH_RPAREN);
    for (int k = 0; k < MAX_DELIM; k++) begin
      if (DLEN_W'(k) < dlen_r && win_nxt[k + 1] != delim_r[k]) win_hit = 1'b0;
    end
  end

  assign is_pfx = (ch == CH_L) || (ch == CH_LU) || (ch == CH_UU) || (ch == CH_8);

  always_comb begin
    mode_nxt   = mode_r;
    pslash_nxt = pslash_r;
    star_nxt   = star_r;
    esc_nxt    = esc_r;
    qkind_nxt  = qkind_r;
    col_nxt    = col_r;
    fcol_nxt   = fcol_r;
    dlen_nxt   = dlen_r;
    fill_nxt   = fill_r;
    pure_nxt   = pure_r;
    rready_nxt = rready_r;
    dwr        = 1'b0;
    win_upd    = 1'b0;
    res_valid  = 1'b0;
    res.found    = (mode_r == MODE_FOUND);
    res.column   = (mode_r == MODE_FOUND) ? fcol_r : '0;
    res.in_block = (mode_r == MODE_BLOCK);
    res.in_raw   = (mode_r == MODE_RAW);
    if (item_valid && line_end) begin
      res_valid = 1'b1;
      if (mode_r != MODE_BLOCK && mode_r != MODE_RAW) mode_nxt = MODE_NORMAL;
      pslash_nxt = 1'b0;
      star_nxt   = 1'b0;
      esc_nxt    = 1'b0;
      fill_nxt   = '0;
      pure_nxt   = 1'b1;
      rready_nxt = 1'b0;
      col_nxt    = '0;
    end else if (item_valid) begin
      case (mode_r)
        MODE_NORMAL: begin
          pslash_nxt = 1'b0;
          if (pslash_r && ch == CH_SLASH) begin
            mode_nxt = MODE_FOUND;
          end else if (pslash_r && ch == CH_STAR) begin
            mode_nxt = MODE_BLOCK;
            star_nxt = 1'b0;
          end else if (ch == CH_SLASH) begin
            pslash_nxt = 1'b1;
            fcol_nxt   = col_r;
          end else if (ch == CH_DQUOTE && rready_r) begin
            mode_nxt = MODE_DELIM;
            dlen_nxt = '0;
          end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
            mode_nxt  = MODE_STRING;
            qkind_nxt = (ch == CH_SQUOTE);
            esc_nxt   = 1'b0;
          end
        end
        MODE_BLOCK: begin
          if (star_r && ch == CH_SLASH) begin
            mode_nxt = MODE_NORMAL;
            star_nxt = 1'b0;
          end else begin
            star_nxt = (ch == CH_STAR);
          end
        end
        MODE_STRING: begin
          if (esc_r) esc_nxt = 1'b0;
          else if (ch == (qkind_r ? CH_SQUOTE : CH_DQUOTE)) mode_nxt = MODE_NORMAL;
          else if (ch == CH_BSLASH) esc_nxt = 1'b1;
        end
        MODE_DELIM: begin
          if (ch == CH_LPAREN) begin
            mode_nxt = MODE_RAW;
            fill_nxt = '0;
          end else if (dlen_r < DLEN_W'(MAX_DELIM)) begin
            dwr      = 1'b1;
            dlen_nxt = dlen_r + DLEN_W'(1);
          end else begin
            mode_nxt = MODE_DEAD;
          end
        end
        MODE_RAW: begin
          win_upd = 1'b1;
          if (win_hit) begin
            mode_nxt = MODE_NORMAL;
            fill_nxt = '0;
          end else begin
            fill_nxt = wfill_push;
          end
        end
        default: ;
      endcase
      rready_nxt = (ch == CH_R) && pure_r;
      if (!is_pfx) pure_nxt = !is_ident(ch);
      if (col_r != '1) col_nxt = col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NORMAL;
      pslash_r <= 1'b0;
      star_r   <= 1'b0;
      esc_r    <= 1'b0;
      qkind_r  <= 1'b0;
      col_r    <= '0;
      fcol_r   <= '0;
      dlen_r   <= '0;
      fill_r   <= '0;
      pure_r   <= 1'b1;
      rready_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      pslash_r <= pslash_nxt;
      star_r   <= star_nxt;
      esc_r    <= esc_nxt;
      qkind_r  <= qkind_nxt;
      col_r    <= col_nxt;
      fcol_r   <= fcol_nxt;
      dlen_r   <= dlen_nxt;
      fill_r   <= fill_nxt;
      pure_r   <= pure_nxt;
      rready_r <= rready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dwr) delim_r[dlen_r[DIDX_W-1:0]] <= ch;
    if (win_upd) begin
      for (int i = 0; i < WIN_SIZE; i++) win_r[i] <= win_nxt[i];
    end
  end

  // delimiter length never passes its limit
  a_dlen: assert property (@(posedge clk) disable iff (!rst_n)
    dlen_r <= DLEN_W'(MAX_DELIM)) else $error("delimiter length overflow");
  // window fill bounded by current terminator length
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= need) else $error("window overfill");
  // a line end always clears the column
  a_col: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && line_end) |=> col_r == '0) else $error("column not cleared");
endmodule

@@ rtl/core/clc_out_q.sv @@
// Two-entry result queue between the scanner and the output port.
// Depends on clc_pkg.
module clc_out_q (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  clc_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output clc_pkg::result_t out_data
);
  import clc_pkg::*;

  result_t    buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_data  = buf_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) rd_r <= ~rd_r;
      if (push) wr_r <= ~wr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_r] <= push_data;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count invalid");
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full queue");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_r != rd_r)) else $error("queue pointers out of step");
endmodule

@@ rtl/core/cpp_line_comment_locator.sv @@
// Top level of the line comment locator: stream ports, scanner and result queue.
// Depends on clc_pkg, clc_scan, clc_out_q.
//
// One character (or line-end marker, in_tlast high) is taken per cycle while in_tready
// is high; a result is produced only for a line end and is written into the result
// queue when its request is accepted. Throughput is one item per clock unless the
// queue is full, set by the per-character lexer state update; the two-entry
// result queue keeps input flowing while a result waits, and in_tready drops
// only when both entries are held. No clearing pass is needed after reset.
module cpp_line_comment_locator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ch
  input  logic        in_tlast,   // is_line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // comment_found, comment_column[15:0],
                                  // in_block_comment, in_raw_string, zero pad
);
  import clc_pkg::*;

  logic    acc;
  logic    res_valid;
  logic    q_full;
  result_t res;
  result_t q_data;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  clc_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (acc),
    .line_end   (in_tlast),
    .ch         (in_tdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  clc_out_q u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data)
  );

  assign out_tdata = {5'd0, q_data.in_raw, q_data.in_block, q_data.column, q_data.found};
endmodule

@@ verif/tb_cpp_line_comment_locator.sv @@
// Testbench for cpp_line_comment_locator: streams C++-like source lines, predicts
// the per-line comment report in SV and checks every result. Depends on clc_pkg.
`timescale 1ns / 1ps

module tb_cpp_line_comment_locator;
  import clc_pkg::*;

  typedef struct {
    logic       eol;
    logic [7:0] ch;
  } src_req_t;

  typedef struct {
    logic        found;
    logic [15:0] column;
    logic        in_block;
    logic        in_raw;
  } line_report_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  cpp_line_comment_locator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [2:0]  lx_mode;
  logic        lx_slash, lx_star, lx_esc, lx_squote;
  logic [15:0] lx_col, lx_found_col;
  logic [7:0]  lx_delim [MAX_DELIM];
  int          lx_dlen;
  logic [7:0]  lx_win [WIN_SIZE];
  int          lx_wfill;
  logic        lx_pure, lx_rready;

  src_req_t     pending_src[$];
  line_report_t expected_reports[$];
  int           errors = 0;
  int           idle_cycles = 0;
  bit           hold_sender = 0;

  function automatic bit ident_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "_";
  endfunction

  task automatic lexer_reset();
    lx_mode = MODE_NORMAL; lx_slash = 0; lx_star = 0; lx_esc = 0; lx_squote = 0;
    lx_col = 0; lx_found_col = 0; lx_dlen = 0; lx_wfill = 0; lx_pure = 1; lx_rready = 0;
    foreach (lx_win[i]) lx_win[i] = 8'h00;
    foreach (lx_delim[i]) lx_delim[i] = 8'h00;
  endtask

  task automatic lexer_step(src_req_t r);
    line_report_t rep;
    logic [7:0] c;
    int need;
    bit hit;
    c = r.ch;
    if (r.eol) begin
      rep.found = (lx_mode == MODE_FOUND);
      if (lx_mode != MODE_BLOCK && lx_mode != MODE_RAW) lx_mode = MODE_NORMAL;
      rep.column = rep.found ? lx_found_col : 16'd0;
      rep.in_block = (lx_mode == MODE_BLOCK);
      rep.in_raw = (lx_mode == MODE_RAW);
      expected_reports = {expected_reports, rep};
      lx_slash = 0; lx_star = 0; lx_esc = 0; lx_wfill = 0; lx_pure = 1; lx_rready = 0;
      lx_col = 0;
      return;
    end
    case (lx_mode)
      MODE_NORMAL: begin
        hit = 0;
        if (lx_slash) begin
          lx_slash = 0;
          if (c == CH_SLASH) begin
            lx_mode = MODE_FOUND; hit = 1;
          end else if (c == CH_STAR) begin
            lx_mode = MODE_BLOCK; lx_star = 0; hit = 1;
          end
        end
        if (!hit) begin
          if (c == CH_SLASH) begin
            lx_slash = 1; lx_found_col = lx_col;
          end else if (c == CH_DQUOTE && lx_rready) begin
            lx_mode = MODE_DELIM; lx_dlen = 0;
          end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            lx_mode = MODE_STRING; lx_squote = (c == CH_SQUOTE); lx_esc = 0;
          end
        end
      end
      MODE_BLOCK: begin
        if (lx_star && c == CH_SLASH) begin
          lx_mode = MODE_NORMAL; lx_star = 0;
        end else lx_star = (c == CH_STAR);
      end
      MODE_STRING: begin
        if (lx_esc) lx_esc = 0;
        else if (c == (lx_squote ? CH_SQUOTE : CH_DQUOTE)) lx_mode = MODE_NORMAL;
        else if (c == CH_BSLASH) lx_esc = 1;
      end
      MODE_DELIM: begin
        if (c == CH_LPAREN) begin
          lx_mode = MODE_RAW; lx_wfill = 0;
        end else if (lx_dlen < MAX_DELIM) begin
          lx_delim[lx_dlen] = c; lx_dlen++;
        end else lx_mode = MODE_DEAD;
      end
      MODE_RAW: begin
        need = lx_dlen + 2;
        if (lx_wfill < need) begin
          lx_win[lx_wfill] = c; lx_wfill++;
        end else begin
          for (int k = 0; k < need - 1; k++) lx_win[k] = lx_win[k+1];
          lx_win[need-1] = c;
        end
        hit = (lx_wfill >= need) && lx_win[0] == CH_RPAREN && lx_win[need-1] == CH_DQUOTE;
        for (int k = 0; k < lx_dlen; k++)
          if (lx_win[k+1] != lx_delim[k]) hit = 0;
        if (hit) begin
          lx_mode = MODE_NORMAL; lx_wfill = 0;
        end
      end
      default: ;
    endcase
    lx_rready = (c == CH_R) && lx_pure;
    if (!(c == CH_L || c == CH_LU || c == CH_UU || c == CH_8)) lx_pure = !ident_char(c);
    if (lx_col != 16'hffff) lx_col++;
  endtask

  // stimulus helpers
  task automatic put_ch(logic [7:0] c);
    src_req_t r;
    r.eol = 0; r.ch = c;
    pending_src = {pending_src, r};
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endtask

  task automatic put_eol();
    src_req_t r;
    r.eol = 1; r.ch = 8'($urandom);
    pending_src = {pending_src, r};
  endtask

  function automatic logic [7:0] pick_char();
    int k;
    k = $urandom_range(0, 19);
    case (k)
      0, 1: return CH_SLASH;
      2: return CH_STAR;
      3: return CH_DQUOTE;
      4: return CH_SQUOTE;
      5: return CH_BSLASH;
      6: return CH_LPAREN;
      7: return CH_RPAREN;
      8: return CH_R;
      9: return CH_L;
      10: return CH_LU;
      11: return CH_UU;
      12: return CH_8;
      13: return CH_USCORE;
      14: return " ";
      15: return 8'($urandom);
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  function automatic string rand_delim(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(97, 122)))};
    return s;
  endfunction

  task automatic random_line();
    int kind, n;
    string d;
    kind = $urandom_range(0, 9);
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) put_ch(pick_char());
    case (kind)
      0: put_str("x = 1; // note");
      1: begin
        put_str("/* open ");
        if ($urandom_range(0, 1)) put_str("*/ y; // t");
      end
      2: begin
        d = rand_delim($urandom_range(0, 3));
        put_str({$urandom_range(0, 1) ? " u8R\"" : " R\"", d, "(a//b"});
        if ($urandom_range(0, 1)) put_str({")", d, "\" //c"});
      end
      3: put_str("s = \"a//\\\"b\"; // q");
      4: put_str("c = '/'; c = '\\''; //z");
      5: put_str({"*/ ) \"", rand_delim($urandom_range(0, 2)), "\" // end"});
      6: put_str({" R\"", rand_delim($urandom_range(15, 18)), "(x"});
      default: ;
    endcase
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) put_ch(pick_char());
    put_eol();
  endtask

  // driver
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0; in_tdata <= 0; in_tlast <= 0;
    end else begin
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 0;
        end else if (pending_src.size() > 0 && !hold_sender) begin
          src_req_t r;
          r = pending_src.pop_front();
          lexer_step(r);
          in_tvalid <= 1; in_tdata <= r.ch; in_tlast <= r.eol;
          if ($urandom_range(0, 5) == 0)
            gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
        end else in_tvalid <= 0;
      end
    end
  end

  // monitor and sink stalls
  always @(posedge clk) begin
    line_report_t e;
    if (!rst_n) out_tready <= 0;
    else begin
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          errors++;
        end else begin
          e = expected_reports.pop_front();
          if (out_tdata[0] !== e.found || out_tdata[16:1] !== e.column ||
              out_tdata[17] !== e.in_block || out_tdata[18] !== e.in_raw ||
              out_tdata[23:19] !== 5'd0) begin
            $display("%0t: mismatch expected found=%0d col=%0d blk=%0d raw=%0d, got %h",
                     $time, e.found, e.column, e.in_block, e.in_raw, out_tdata);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 15) == 0) out_tready <= 0;
      else if ($urandom_range(0, 2) == 0) out_tready <= 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int lines;
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tlast = 0; out_tready = 0;
    lexer_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    // directed lines
    put_str("int a; // hi"); put_eol();
    put_str("/* multi"); put_eol();
    put_str("still */ b; //x"); put_eol();
    put_str("s=\"//\"; q='/'"); put_eol();
    put_str("s=\"abc\\"); put_eol();
    put_str("x = LR\"ab(text"); put_eol();
    put_str("more )ab\" //k"); put_eol();
    put_str("R\"xyz"); put_eol();
    put_str({"R\"", rand_delim(17), "(//"}); put_eol();
    put_str("uR\"(a)\"//"); put_eol();
    put_str("xR\"(/"); put_eol();
    put_str("a /"); put_eol();
    put_ch(8'hff); put_ch(8'h00); put_str("//"); put_eol();
    wait (pending_src.size() == 0 && expected_reports.size() == 0);
    hold_sender = 1;
    repeat (3) @(posedge clk);
    hold_sender = 0;
    lines = 0;
    while (lines < 55) begin
      random_line();
      lines++;
    end
    wait (pending_src.size() == 0);
    wait (expected_reports.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/clc_pkg.sv
rtl/core/clc_scan.sv
rtl/core/clc_out_q.sv
rtl/core/cpp_line_comment_locator.sv
verif/tb_cpp_line_comment_locator.sv
